>>> sv/rclfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rclfp_pkg
// Shared types, constants and the CRC-8 step for the RC link frame parser.
// ----------------------------------------------------------------------------
package rclfp_pkg;

    localparam int BYTE_W                = 8;
    localparam int CHANNEL_PAYLOAD_BYTES = 22;
    localparam int CHANNEL_COUNT         = 16;
    localparam int CHANNEL_BITS          = 11;
    localparam int PAYLOAD_BITS          = CHANNEL_PAYLOAD_BYTES * BYTE_W;
    localparam int STORE_IDX_W           = $clog2(CHANNEL_PAYLOAD_BYTES);
    localparam int CHAN_IDX_W            = $clog2(CHANNEL_COUNT);
    localparam int LEN_W                 = 6;

    // APB
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_SYNC_ADDR = 2'd0;
    localparam logic [1:0] REG_CHAN_TYPE = 2'd1;
    localparam logic [1:0] REG_CRC_POLY  = 2'd2;
    localparam logic [1:0] REG_MAX_LEN   = 2'd3;

    localparam logic [7:0]       RST_SYNC_ADDR = 8'd200;
    localparam logic [7:0]       RST_CHAN_TYPE = 8'd22;
    localparam logic [7:0]       RST_CRC_POLY  = 8'hD5;
    localparam logic [LEN_W-1:0] RST_MAX_LEN   = 6'd62;

    localparam logic [7:0]       CRC_MSB       = 8'h80;
    localparam logic [LEN_W-1:0] MIN_FRAME_LEN = 6'd2;
    localparam logic [LEN_W-1:0] CHAN_FRAME_LEN = LEN_W'(CHANNEL_PAYLOAD_BYTES + 2);

    typedef enum logic [2:0] {
        PH_HUNT = 3'b001,
        PH_LEN  = 3'b010,
        PH_BODY = 3'b100
    } t_phase;

    typedef enum logic [1:0] {
        KIND_FRAME   = 2'd0,
        KIND_CHANNEL = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0]       sync_address;
        logic [7:0]       channels_frame_type;
        logic [7:0]       crc_polynomial;
        logic [LEN_W-1:0] max_frame_length;
    } t_cfg;

    // one finished frame, handed from the parser to the emitter
    typedef struct packed {
        t_kind                   kind;
        logic [7:0]              frame_type;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_evt;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // one byte through the CRC register, MSB first: same as the 256-entry table
    function automatic logic [7:0] crc8_step(input logic [7:0] c_in,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = c_in;
        for (int b = 0; b < 8; b++) begin
            c = {c[6:0], 1'b0} ^ (((c & CRC_MSB) != 8'h00) ? poly : 8'h00);
        end
        return c;
    endfunction

endpackage

>>> sv/rclfp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rclfp_in_if / rclfp_out_if
// Valid/ready channels carrying received bytes in and parser results out.
// ----------------------------------------------------------------------------
interface rclfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       burst_end;

    modport source (output valid, output rx_byte, output burst_end, input ready);
    modport sink   (input valid, input rx_byte, input burst_end, output ready);
endinterface

interface rclfp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  frame_type;
    logic [3:0]  channel_index;
    logic [10:0] channel_value;
    logic        last_of_run;

    modport source (output valid, output result_kind, output frame_type,
                    output channel_index, output channel_value, output last_of_run,
                    input ready);
    modport sink   (input valid, input result_kind, input frame_type,
                    input channel_index, input channel_value, input last_of_run,
                    output ready);
endinterface

>>> sv/rc_link_frame_parser_crc8.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_link_frame_parser_crc8
// Receiver for sync/length/type/payload/CRC-8 link frames with channel decode.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one received byte per word plus a line-idle flag. The parser
//   takes one byte per cycle while its frame queue has room.
//   o_out carries result words: one per finished frame (good or failed CRC),
//   or sixteen channel words for a good RC channels frame; last_of_run marks
//   the final word of each frame.
//   After its check byte is accepted, a frame is written into the frame queue,
//   then, with the emitter idle, loaded into the emitter's output register.
//   The emitter sends one word per cycle while the receiver takes them, and
//   the frame queue (QUEUE_DEPTH frames) lets the parser go on taking bytes.
//   Input ready drops only when the queue is full.
//   Output stall: words hold until taken; the queue fills, then input stalls.
//   Reset (synchronous, active low) returns the parser to sync hunt, empties
//   the queue and loads the register defaults. The user must write registers
//   over APB only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module rc_link_frame_parser_crc8 #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    rclfp_in_if.sink                     i_in,
    rclfp_out_if.source                  o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rclfp_pkg::ADDR_W-1:0] paddr,
    input  logic [rclfp_pkg::DATA_W-1:0] pwdata,
    output logic [rclfp_pkg::DATA_W-1:0] prdata,
    output logic                         pready
);
    import rclfp_pkg::*;

    t_cfg   w_cfg;
    t_evt   w_evt, w_head;
    t_qstat w_qstat;
    logic   w_push, w_pop;

    rclfp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    rclfp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (w_cfg),
        .i_qstat (w_qstat),
        .o_push  (w_push),
        .o_evt   (w_evt)
    );

    rclfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_evt   (w_evt),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_qstat (w_qstat)
    );

    rclfp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_qstat (w_qstat),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

>>> sv/rclfp_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rclfp_cfg
// APB register file: sync address, channels type, CRC polynomial, max length.
// ----------------------------------------------------------------------------
module rclfp_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rclfp_pkg::ADDR_W-1:0] paddr,
    input  logic [rclfp_pkg::DATA_W-1:0] pwdata,
    output logic [rclfp_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output rclfp_pkg::t_cfg             o_cfg
);
    import rclfp_pkg::*;

    t_cfg       r_cfg;
    logic       w_wr;
    logic [1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[3:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_address        <= RST_SYNC_ADDR;
            r_cfg.channels_frame_type <= RST_CHAN_TYPE;
            r_cfg.crc_polynomial      <= RST_CRC_POLY;
            r_cfg.max_frame_length    <= RST_MAX_LEN;
        end else if (w_wr) begin
            case (w_idx)
                REG_SYNC_ADDR: r_cfg.sync_address        <= pwdata[7:0];
                REG_CHAN_TYPE: r_cfg.channels_frame_type <= pwdata[7:0];
                REG_CRC_POLY:  r_cfg.crc_polynomial      <= pwdata[7:0];
                REG_MAX_LEN:   r_cfg.max_frame_length    <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_SYNC_ADDR: prdata = DATA_W'(r_cfg.sync_address);
            REG_CHAN_TYPE: prdata = DATA_W'(r_cfg.channels_frame_type);
            REG_CRC_POLY:  prdata = DATA_W'(r_cfg.crc_polynomial);
            REG_MAX_LEN:   prdata = DATA_W'(r_cfg.max_frame_length);
            default:       prdata = '0;
        endcase
    end

endmodule

>>> sv/rclfp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rclfp_front
// Byte parser: sync hunt, length check, CRC, payload capture, frame events.
// ----------------------------------------------------------------------------
module rclfp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    rclfp_in_if.sink        i_in,
    input  rclfp_pkg::t_cfg i_cfg,
    input  rclfp_pkg::t_qstat i_qstat,
    output logic            o_push,
    output rclfp_pkg::t_evt o_evt
);
    import rclfp_pkg::*;

    t_phase                                  r_phase, n_phase;
    logic [LEN_W-1:0]                        r_frame_len, n_frame_len;
    logic [LEN_W-1:0]                        r_bytes_left, n_bytes_left;
    logic [7:0]                              r_crc, n_crc;
    logic [7:0]                              r_type, n_type;
    logic [CHANNEL_PAYLOAD_BYTES-1:0][7:0]   r_payload;

    logic             w_acc;
    logic [7:0]       w_byte;
    logic [7:0]       w_crc;
    logic [LEN_W-1:0] w_pos;
    logic [LEN_W-1:0] w_slot;
    logic             w_store;
    logic             w_bad_len;

    assign i_in.ready = !i_qstat.full;
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_byte     = i_in.rx_byte;
    assign w_crc      = crc8_step(r_crc ^ w_byte, i_cfg.crc_polynomial);
    assign w_pos      = r_frame_len - r_bytes_left;   // 0 is the type byte
    assign w_slot     = w_pos - 6'd1;
    assign w_bad_len  = (w_byte < 8'(MIN_FRAME_LEN)) ||
                        (w_byte > 8'(i_cfg.max_frame_length));
    // check byte is never stored; bytes past the channel payload size are dropped
    assign w_store    = w_acc && (r_phase == PH_BODY) && (w_pos != '0) &&
                        (r_bytes_left > 6'd1) &&
                        (w_slot < LEN_W'(CHANNEL_PAYLOAD_BYTES));

    always_comb begin
        n_phase      = r_phase;
        n_frame_len  = r_frame_len;
        n_bytes_left = r_bytes_left;
        n_crc        = r_crc;
        n_type       = r_type;
        o_push       = 1'b0;
        o_evt.kind       = KIND_FRAME;
        o_evt.frame_type = r_type;
        o_evt.payload    = r_payload;
        if (w_acc) begin
            case (r_phase)
                PH_HUNT: begin
                    if (w_byte == i_cfg.sync_address) n_phase = PH_LEN;
                end
                PH_LEN: begin
                    if (w_bad_len) begin
                        n_phase = (w_byte == i_cfg.sync_address) ? PH_LEN : PH_HUNT;
                    end else begin
                        n_frame_len  = w_byte[LEN_W-1:0];
                        n_bytes_left = w_byte[LEN_W-1:0];
                        n_crc        = 8'h00;
                        n_phase      = PH_BODY;
                    end
                end
                PH_BODY: begin
                    n_crc        = w_crc;
                    if (w_pos == '0) n_type = w_byte;
                    n_bytes_left = r_bytes_left - 6'd1;
                    if (r_bytes_left == 6'd1) begin
                        o_push  = 1'b1;
                        n_phase = PH_HUNT;
                        if (w_crc != 8'h00) begin
                            o_evt.kind = KIND_ERROR;
                        end else if (r_type == i_cfg.channels_frame_type &&
                                     r_frame_len == CHAN_FRAME_LEN) begin
                            o_evt.kind = KIND_CHANNEL;
                        end
                    end
                end
                default: n_phase = PH_HUNT;
            endcase
            if (i_in.burst_end) n_phase = PH_HUNT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_frame_len  <= '0;
            r_bytes_left <= '0;
            r_crc        <= '0;
            r_type       <= '0;
        end else begin
            r_phase      <= n_phase;
            r_frame_len  <= n_frame_len;
            r_bytes_left <= n_bytes_left;
            r_crc        <= n_crc;
            r_type       <= n_type;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store) r_payload[w_slot[STORE_IDX_W-1:0]] <= w_byte;
    end

endmodule

>>> sv/rclfp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rclfp_queue
// Small FIFO of finished frames between the parser and the result emitter.
// ----------------------------------------------------------------------------
module rclfp_queue #(
    parameter int DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rclfp_pkg::t_evt   i_evt,
    input  logic              i_pop,
    output rclfp_pkg::t_evt   o_head,
    output rclfp_pkg::t_qstat o_qstat
);
    import rclfp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    t_evt          r_mem [DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_count;
    logic          w_push, w_pop;

    assign o_qstat.full  = (r_count == CW'(DEPTH));
    assign o_qstat.empty = (r_count == '0);
    assign w_push = i_push && !o_qstat.full;
    assign w_pop  = i_pop && !o_qstat.empty;
    assign o_head = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + PW'(1);
            if (w_pop)  r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + PW'(1);
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wptr] <= i_evt;
    end

endmodule

>>> sv/rclfp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rclfp_back
// Result emitter: one word per frame, or sixteen channel words per RC frame.
// ----------------------------------------------------------------------------
module rclfp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rclfp_pkg::t_evt   i_head,
    input  rclfp_pkg::t_qstat i_qstat,
    output logic              o_pop,
    rclfp_out_if.source       o_out
);
    import rclfp_pkg::*;

    logic                    r_valid;
    t_kind                   r_kind;
    logic [7:0]              r_type;
    logic [CHAN_IDX_W-1:0]   r_idx;
    logic [PAYLOAD_BITS-1:0] r_shift;

    logic w_last, w_take, w_step;

    assign w_last = (r_kind != KIND_CHANNEL) || (r_idx == CHAN_IDX_W'(CHANNEL_COUNT - 1));
    assign w_take = r_valid && o_out.ready;
    assign o_pop  = !i_qstat.empty && (!r_valid || (w_take && w_last));
    assign w_step = w_take && !w_last;

    assign o_out.valid         = r_valid;
    assign o_out.result_kind   = r_kind;
    assign o_out.frame_type    = r_type;
    assign o_out.channel_index = r_idx;
    assign o_out.channel_value = (r_kind == KIND_CHANNEL) ? r_shift[CHANNEL_BITS-1:0] : '0;
    assign o_out.last_of_run   = w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (w_take && w_last) begin
            r_valid <= 1'b0;
        end
    end

    // channels leave LSB first, 11 bits per word
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind  <= i_head.kind;
            r_type  <= i_head.frame_type;
            r_idx   <= '0;
            r_shift <= i_head.payload;
        end else if (w_step) begin
            r_idx   <= r_idx + CHAN_IDX_W'(1);
            r_shift <= r_shift >> CHANNEL_BITS;
        end
    end

endmodule

>>> sv/rclfp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rclfp_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module rclfp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [1:0]  i_kind,
    input logic [3:0]  i_index,
    input logic [10:0] i_value,
    input logic        i_last
);
    import rclfp_pkg::*;

    // a word stalled by the receiver must not change
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_kind) && $stable(i_index) &&
                                $stable(i_value) && $stable(i_last))
        else $error("result word changed while stalled");

    // channel words come back to back with rising index until the last one
    a_chan_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready && i_kind == KIND_CHANNEL && !i_last |=>
            i_valid && i_kind == KIND_CHANNEL && i_index == $past(i_index) + 4'd1)
        else $error("channel run broken");

    // last flag: every non-channel word is last, a channel word only at the top index
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_last == ((i_kind != KIND_CHANNEL) ||
                                (i_index == 4'(CHANNEL_COUNT - 1)))))
        else $error("last_of_run wrong");

    // non-channel words carry zero index and value
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind != KIND_CHANNEL |-> i_index == '0 && i_value == '0)
        else $error("non-channel word has channel fields");

    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_valid)
        else $error("result valid right after reset");

endmodule

bind rc_link_frame_parser_crc8 rclfp_checker u_rclfp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_out.valid),
    .i_ready (o_out.ready),
    .i_kind  (o_out.result_kind),
    .i_index (o_out.channel_index),
    .i_value (o_out.channel_value),
    .i_last  (o_out.last_of_run)
);

>>> test/rc_link_frame_parser_crc8_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_link_frame_parser_crc8_checker
// Watches the byte and result channels and the APB bus, runs its own copy of
// the frame parser on every accepted byte, and compares each result word in
// order against the words that parser says are due.
// ----------------------------------------------------------------------------
module rc_link_frame_parser_crc8_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    rclfp_in_if                          i_in_mon,
    rclfp_out_if                         i_out_mon,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic                         i_pready,
    input  logic [rclfp_pkg::ADDR_W-1:0] i_paddr,
    input  logic [rclfp_pkg::DATA_W-1:0] i_pwdata,
    output int                           o_fail_count,
    output int                           o_pending
);
    import rclfp_pkg::*;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  ftype;
        logic [3:0]  idx;
        logic [10:0] value;
        logic        last;
    } t_result;

    t_cfg       cfg;
    t_phase     rx_phase;
    logic [5:0] frame_len;
    logic [5:0] bytes_left;
    logic [7:0] crc_acc;
    logic [7:0] type_byte;
    logic [7:0] payload [CHANNEL_PAYLOAD_BYTES];
    logic [7:0] crc_lut [256];
    t_result    words_due[$];

    initial o_fail_count = 0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        o_fail_count++;
    endtask

    function automatic logic [7:0] lut_value(input logic [7:0] index,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = index;
        repeat (8) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    task automatic load_crc_lut(input logic [7:0] poly);
        for (int v = 0; v < 256; v++) begin
            crc_lut[v] = lut_value(8'(v), poly);
        end
    endtask

    task automatic parse_rx_byte(input logic [7:0] b, input logic idle);
        int                      pos;
        logic [PAYLOAD_BITS-1:0] flat;
        t_result                 r;
        case (rx_phase)
            PH_HUNT: begin
                if (b == cfg.sync_address) rx_phase = PH_LEN;
            end
            PH_LEN: begin
                if (b < 8'd2 || b > {2'b00, cfg.max_frame_length}) begin
                    // a rejected length that is itself a sync byte restarts the frame
                    rx_phase = (b == cfg.sync_address) ? PH_LEN : PH_HUNT;
                end else begin
                    frame_len  = b[5:0];
                    bytes_left = b[5:0];
                    crc_acc    = 8'h00;
                    rx_phase   = PH_BODY;
                end
            end
            default: begin
                pos     = int'(frame_len) - int'(bytes_left);
                crc_acc = crc_lut[crc_acc ^ b];
                if (pos == 0) begin
                    type_byte = b;
                end else if (bytes_left > 6'd1 && pos - 1 < CHANNEL_PAYLOAD_BYTES) begin
                    payload[pos - 1] = b;
                end
                bytes_left = bytes_left - 6'd1;
                if (bytes_left == 6'd0) begin
                    r = '0;
                    r.ftype = type_byte;
                    r.last  = 1'b1;
                    if (crc_acc != 8'h00) begin
                        r.kind = KIND_ERROR;
                        words_due.push_back(r);
                    end else if (type_byte == cfg.channels_frame_type &&
                                 int'(frame_len) == CHANNEL_PAYLOAD_BYTES + 2) begin
                        for (int i = 0; i < CHANNEL_PAYLOAD_BYTES; i++) begin
                            flat[8*i +: 8] = payload[i];
                        end
                        for (int c = 0; c < CHANNEL_COUNT; c++) begin
                            r.kind  = KIND_CHANNEL;
                            r.idx   = 4'(c);
                            r.value = flat[c*CHANNEL_BITS +: CHANNEL_BITS];
                            r.last  = (c == CHANNEL_COUNT - 1);
                            words_due.push_back(r);
                        end
                    end else begin
                        r.kind = KIND_FRAME;
                        words_due.push_back(r);
                    end
                    rx_phase = PH_HUNT;
                end
            end
        endcase
        if (idle) rx_phase = PH_HUNT;
    endtask

    task automatic check_word(input t_result got);
        t_result want;
        if (words_due.size() == 0) begin
            report_mismatch($sformatf("unexpected word kind=%0d type=%0h idx=%0d val=%0d",
                                      got.kind, got.ftype, got.idx, got.value));
            return;
        end
        want = words_due.pop_front();
        if (got.kind !== want.kind)
            report_mismatch($sformatf("result_kind %0d, want %0d", got.kind, want.kind));
        if (got.ftype !== want.ftype)
            report_mismatch($sformatf("frame_type %0h, want %0h", got.ftype, want.ftype));
        if (got.idx !== want.idx)
            report_mismatch($sformatf("channel_index %0d, want %0d", got.idx, want.idx));
        if (got.value !== want.value)
            report_mismatch($sformatf("channel_value %0d, want %0d (ch %0d)",
                                      got.value, want.value, want.idx));
        if (got.last !== want.last)
            report_mismatch($sformatf("last_of_run %0b, want %0b", got.last, want.last));
    endtask

    always @(posedge i_clk) begin
        t_result got;
        if (!i_rst_n) begin
            cfg.sync_address        = RST_SYNC_ADDR;
            cfg.channels_frame_type = RST_CHAN_TYPE;
            cfg.crc_polynomial      = RST_CRC_POLY;
            cfg.max_frame_length    = RST_MAX_LEN;
            rx_phase   = PH_HUNT;
            frame_len  = '0;
            bytes_left = '0;
            crc_acc    = '0;
            type_byte  = '0;
            for (int i = 0; i < CHANNEL_PAYLOAD_BYTES; i++) payload[i] = '0;
            load_crc_lut(RST_CRC_POLY);
            words_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_SYNC_ADDR: cfg.sync_address        = i_pwdata[7:0];
                    REG_CHAN_TYPE: cfg.channels_frame_type = i_pwdata[7:0];
                    REG_CRC_POLY: begin
                        cfg.crc_polynomial = i_pwdata[7:0];
                        load_crc_lut(i_pwdata[7:0]);
                    end
                    REG_MAX_LEN:   cfg.max_frame_length    = i_pwdata[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                parse_rx_byte(i_in_mon.rx_byte, i_in_mon.burst_end);
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                got.kind  = t_kind'(i_out_mon.result_kind);
                got.ftype = i_out_mon.frame_type;
                got.idx   = i_out_mon.channel_index;
                got.value = i_out_mon.channel_value;
                got.last  = i_out_mon.last_of_run;
                check_word(got);
            end
        end
        o_pending <= words_due.size();
    end

endmodule

>>> test/rc_link_frame_parser_crc8_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_link_frame_parser_crc8_test
// Drives byte streams into the frame parser: a short directed set of length,
// check and idle-line corner cases, then random frames with random content
// under four register settings and three stall patterns. Result checking is
// done by the checker module instantiated next to the block.
// ----------------------------------------------------------------------------
module rc_link_frame_parser_crc8_test;
    import rclfp_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int fail_count;
    int words_pending;
    int send_idle_pct = 10;
    int recv_idle_pct = 62;
    int bytes_sent    = 0;
    int quiet_cycles  = 0;

    logic [7:0] cur_sync;
    logic [7:0] cur_chan;
    logic [7:0] cur_poly;
    logic [5:0] cur_max;

    rclfp_in_if  in_ch ();
    rclfp_out_if out_ch ();

    rc_link_frame_parser_crc8 uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    rc_link_frame_parser_crc8_checker result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (words_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // result-side back-pressure
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (in_ch.valid && in_ch.ready) ||
            (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("rc_link_frame_parser_crc8 verification failed");
            $finish;
        end
    end

    // bit-serial CRC-8, MSB first, over the current polynomial
    function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[7] ^ data[i];
            c  = {c[6:0], 1'b0} ^ (fb ? cur_poly : 8'h00);
        end
        return c;
    endfunction

    task automatic reg_write(input logic [1:0] idx, input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'($urandom()), val};  // upper bits must be ignored
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_config(input logic [7:0] sync, input logic [7:0] chan,
                                input logic [7:0] poly, input logic [5:0] max_len);
        reg_write(REG_SYNC_ADDR, sync);
        reg_write(REG_CHAN_TYPE, chan);
        reg_write(REG_CRC_POLY, poly);
        reg_write(REG_MAX_LEN, {2'($urandom()), max_len});
        cur_sync = sync;
        cur_chan = chan;
        cur_poly = poly;
        cur_max  = max_len;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic be);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.rx_byte   <= b;
        in_ch.burst_end <= be;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // stop sending, let every due word come out, then idle for a slack period
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (words_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // fill: 0 random payload, 1 all ones, 2 all zeros
    // cut_pos >= 0 raises burst_end on that body byte and drops the rest
    task automatic send_frame(input int len, input logic [7:0] ftype, input bit corrupt,
                              input int cut_pos, input int fill);
        logic [7:0] crc;
        logic [7:0] b;
        crc = 8'h00;
        send_byte(cur_sync, 1'b0);
        send_byte(8'(len), 1'b0);
        for (int i = 0; i < len; i++) begin
            if (i == 0) begin
                b = ftype;
            end else if (i == len - 1) begin
                b = corrupt ? (crc ^ 8'($urandom_range(1, 255))) : crc;
            end else begin
                case (fill)
                    1:       b = 8'hFF;
                    2:       b = 8'h00;
                    default: b = 8'($urandom());
                endcase
            end
            if (i < len - 1) crc = crc_update(crc, b);
            send_byte(b, i == cut_pos);
            if (i == cut_pos) break;
        end
    endtask

    task automatic bad_length_pair();
        int         r;
        logic [7:0] len;
        r = $urandom_range(0, 3);
        if (r == 0)      len = 8'($urandom_range(0, 1));
        else if (r == 1) len = cur_sync;
        else             len = 8'($urandom_range(int'(cur_max) + 1, 255));
        send_byte(cur_sync, 1'b0);
        send_byte(len, 1'b0);
    endtask

    task automatic random_traffic(input int n_bytes);
        int         start;
        int         r;
        int         len;
        int         cut;
        int         fill;
        logic [7:0] ftype;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                send_byte(8'($urandom()), $urandom_range(0, 19) == 0);
            end else if (r < 16) begin
                bad_length_pair();
            end else begin
                ftype = 8'($urandom());
                if (r < 50 && cur_max >= 6'(CHANNEL_PAYLOAD_BYTES + 2)) begin
                    len   = CHANNEL_PAYLOAD_BYTES + 2;
                    ftype = cur_chan;
                end else if (r < 58) begin
                    len   = $urandom_range(2, int'(cur_max));
                    ftype = cur_chan;
                end else if (r < 80) begin
                    len = $urandom_range(2, (cur_max < 6'd8) ? int'(cur_max) : 8);
                end else begin
                    len = $urandom_range(2, int'(cur_max));
                end
                cut  = ($urandom_range(0, 19) == 0) ? $urandom_range(0, len - 1) : -1;
                fill = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0;
                send_frame(len, ftype, $urandom_range(0, 99) < 15, cut, fill);
            end
        end
    endtask

    initial begin
        in_ch.valid     <= 1'b0;
        in_ch.rx_byte   <= 8'h00;
        in_ch.burst_end <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        i_rst_n         <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // phase 1: register defaults, light sender gaps, heavy result stalls
        apply_config(RST_SYNC_ADDR, RST_CHAN_TYPE, RST_CRC_POLY, RST_MAX_LEN);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(cur_sync, 1'b0);            // length below minimum
        send_byte(8'd1, 1'b0);
        send_byte(cur_sync, 1'b0);            // rejected length equal to sync
        send_frame(2, 8'hFF, 1'b0, -1, 0);    // shortest frame, no payload
        send_byte(cur_sync, 1'b0);            // length above limit
        send_byte(8'(int'(cur_max) + 1), 1'b0);
        send_frame(3, 8'h00, 1'b1, -1, 0);    // failed check
        send_frame(5, 8'h5A, 1'b0, 1, 0);     // line idle inside the frame
        send_frame(3, cur_chan, 1'b0, 2, 1);  // idle on the check byte still reports
        random_traffic(10);
        wait_drained();                       // sender holds off until all words are out
        random_traffic(10);

        // phase 2: heavy sender gaps, light result stalls
        wait_drained();
        send_idle_pct = 62;
        recv_idle_pct = 10;
        apply_config(8'h00, 8'hFF, 8'h07, 6'd62);
        random_traffic(30);

        // phase 3: no gaps either side
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_config(8'hFF, 8'h00, 8'hFF, 6'd30);
        random_traffic(30);

        // phase 4: shortest allowed frames, null polynomial passes everything
        wait_drained();
        apply_config(8'($urandom()), 8'($urandom()), 8'h00, MIN_FRAME_LEN);
        random_traffic(25);

        wait_drained();
        if (fail_count == 0 && words_pending == 0) begin
            $display("rc_link_frame_parser_crc8 verification clean");
        end else begin
            $display("rc_link_frame_parser_crc8 verification failed");
        end
        $finish;
    end

endmodule
